// ----- rtl/ascu_pkg.sv -----
// shared types, constants and helpers for the audio sync sample correction unit
// no dependencies; every other file imports this package
package ascu_pkg;

  // field widths
  localparam int N_W    = 16;
  localparam int CLK_W  = 48;
  localparam int WANT_W = 17;
  localparam int DIFF_W = 49;
  localparam int SUM_W  = 56;
  localparam int CNT_W  = 5;
  localparam int COEF_W = 16;
  localparam int THR_W  = 32;
  localparam int RATE_W = 19;
  localparam int FRAC_W = 16;

  // shared multiplier: 56-bit operand in two 28-bit chunks times a 19-bit operand
  localparam int MUL_A_W     = 56;
  localparam int MUL_CHUNK_W = 28;
  localparam int MUL_B_W     = 19;
  localparam int PROD_W      = MUL_CHUNK_W + MUL_B_W;
  localparam int ACC_W       = MUL_A_W + MUL_B_W;
  localparam int ACCQ_W      = ACC_W - FRAC_W;

  // config port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int AVG_MEASURES_DEF = 20;

  localparam logic [COEF_W-1:0] COEF_RST   = COEF_W'(52016);
  localparam logic [THR_W-1:0]  CORR_RST   = THR_W'(1311);
  localparam logic [THR_W-1:0]  NOSYNC_RST = THR_W'(655360);
  localparam logic [RATE_W-1:0] RATE_RST   = RATE_W'(48000);

  // floor(x/10) for x below 2^20: multiply by ceil(2^23/10), keep the bits from 23 up
  localparam int DIV_IN_W     = 20;
  localparam int DIV_SHIFT    = 23;
  localparam int DIV_PROD_W   = 40;
  localparam logic [DIV_IN_W-1:0] DIV10_RECIP = DIV_IN_W'(838861);

  typedef enum logic [2:0] {
    REG_MASTER     = 3'd0,
    REG_COEF       = 3'd1,
    REG_CORR_THR   = 3'd2,
    REG_NOSYNC_THR = 3'd3,
    REG_RATE       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              master;
    logic [COEF_W-1:0] coef;
    logic [THR_W-1:0]  corr_thr;
    logic [THR_W-1:0]  nosync_thr;
    logic [RATE_W-1:0] rate;
  } cfg_t;

  // microcode fields
  typedef enum logic [1:0] {MUL_NONE, MUL_LO, MUL_HI} mul_op_t;
  typedef enum logic {A_SUM, A_DIFF} a_sel_t;
  typedef enum logic [1:0] {B_COEF, B_COMPL, B_RATE} b_sel_t;
  typedef enum logic [3:0] {
    ACT_NOP, ACT_DIFF, ACT_ABS, ACT_CHECK, ACT_UPDATE, ACT_MAG, ACT_THRESH, ACT_CLIP, ACT_DONE
  } act_t;
  typedef enum logic [2:0] {JMP_NONE, JMP_MASTER, JMP_NOSYNC, JMP_COUNTING, JMP_BELOW} jmp_t;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] ST_DIFF   = 4'd0;
  localparam logic [STEP_W-1:0] ST_ABS    = 4'd1;
  localparam logic [STEP_W-1:0] ST_CHECK  = 4'd2;
  localparam logic [STEP_W-1:0] ST_PM_LO  = 4'd3;
  localparam logic [STEP_W-1:0] ST_PM_HI  = 4'd4;
  localparam logic [STEP_W-1:0] ST_UPDATE = 4'd5;
  localparam logic [STEP_W-1:0] ST_MAG    = 4'd6;
  localparam logic [STEP_W-1:0] ST_AM_LO  = 4'd7;
  localparam logic [STEP_W-1:0] ST_AM_HI  = 4'd8;
  localparam logic [STEP_W-1:0] ST_THRESH = 4'd9;
  localparam logic [STEP_W-1:0] ST_SM_LO  = 4'd10;
  localparam logic [STEP_W-1:0] ST_SM_HI  = 4'd11;
  localparam logic [STEP_W-1:0] ST_CLIP   = 4'd12;
  localparam logic [STEP_W-1:0] ST_DONE   = 4'd13;

  typedef struct packed {
    act_t              act;
    mul_op_t           mul;
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } uword_t;

  function automatic logic [WANT_W-1:0] div10(input logic [DIV_IN_W-1:0] x);
    logic [DIV_PROD_W-1:0] p;
    p = DIV_PROD_W'(x) * DIV_PROD_W'(DIV10_RECIP);
    return p[DIV_SHIFT +: WANT_W];
  endfunction

endpackage

// ----- rtl/ascu_if.sv -----
// request channels of the audio sync sample correction unit
// depends on ascu_pkg for field widths
interface ascu_in_if import ascu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [N_W-1:0]          frame_samples;
  logic signed [CLK_W-1:0] audio_clock;
  logic signed [CLK_W-1:0] master_clock;
  logic                    clocks_valid;

  modport source (output valid, frame_samples, audio_clock, master_clock, clocks_valid,
                  input ready);
  modport sink (input valid, frame_samples, audio_clock, master_clock, clocks_valid,
                output ready);
endinterface

interface ascu_out_if import ascu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WANT_W-1:0] wanted_samples;

  modport source (output valid, wanted_samples, input ready);
  modport sink (input valid, wanted_samples, output ready);
endinterface

// ----- rtl/ascu_cfg.sv -----
// apb-style configuration registers
// depends on ascu_pkg for register indexes, reset values and cfg_t
module ascu_cfg import ascu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.master     <= 1'b0;
      cfg.coef       <= COEF_RST;
      cfg.corr_thr   <= CORR_RST;
      cfg.nosync_thr <= NOSYNC_RST;
      cfg.rate       <= RATE_RST;
    end else if (wr) begin
      case (idx)
        REG_MASTER:     cfg.master     <= pwdata[0];
        REG_COEF:       cfg.coef       <= pwdata[COEF_W-1:0];
        REG_CORR_THR:   cfg.corr_thr   <= pwdata[THR_W-1:0];
        REG_NOSYNC_THR: cfg.nosync_thr <= pwdata[THR_W-1:0];
        REG_RATE:       cfg.rate       <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MASTER:     prdata = DATA_W'(cfg.master);
      REG_COEF:       prdata = DATA_W'(cfg.coef);
      REG_CORR_THR:   prdata = cfg.corr_thr;
      REG_NOSYNC_THR: prdata = cfg.nosync_thr;
      REG_RATE:       prdata = DATA_W'(cfg.rate);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- rtl/ascu_rom.sv -----
// microcode program: one control word per step
// depends on ascu_pkg for uword_t and step addresses
module ascu_rom import ascu_pkg::*; (
  input  logic [STEP_W-1:0] step,
  output uword_t            uw
);

  always_comb begin
    unique case (step)
      ST_DIFF:   uw = '{ACT_DIFF,   MUL_NONE, A_SUM,  B_COEF,  JMP_MASTER,   ST_DONE};
      ST_ABS:    uw = '{ACT_ABS,    MUL_NONE, A_SUM,  B_COEF,  JMP_NONE,     ST_DONE};
      ST_CHECK:  uw = '{ACT_CHECK,  MUL_NONE, A_SUM,  B_COEF,  JMP_NOSYNC,   ST_DONE};
      ST_PM_LO:  uw = '{ACT_NOP,    MUL_LO,   A_SUM,  B_COEF,  JMP_NONE,     ST_DONE};
      ST_PM_HI:  uw = '{ACT_NOP,    MUL_HI,   A_SUM,  B_COEF,  JMP_NONE,     ST_DONE};
      ST_UPDATE: uw = '{ACT_UPDATE, MUL_NONE, A_SUM,  B_COEF,  JMP_COUNTING, ST_DONE};
      ST_MAG:    uw = '{ACT_MAG,    MUL_NONE, A_SUM,  B_COEF,  JMP_NONE,     ST_DONE};
      ST_AM_LO:  uw = '{ACT_NOP,    MUL_LO,   A_SUM,  B_COMPL, JMP_NONE,     ST_DONE};
      ST_AM_HI:  uw = '{ACT_NOP,    MUL_HI,   A_SUM,  B_COMPL, JMP_NONE,     ST_DONE};
      ST_THRESH: uw = '{ACT_THRESH, MUL_NONE, A_SUM,  B_COEF,  JMP_BELOW,    ST_DONE};
      ST_SM_LO:  uw = '{ACT_NOP,    MUL_LO,   A_DIFF, B_RATE,  JMP_NONE,     ST_DONE};
      ST_SM_HI:  uw = '{ACT_NOP,    MUL_HI,   A_DIFF, B_RATE,  JMP_NONE,     ST_DONE};
      ST_CLIP:   uw = '{ACT_CLIP,   MUL_NONE, A_SUM,  B_COEF,  JMP_NONE,     ST_DONE};
      default:   uw = '{ACT_DONE,   MUL_NONE, A_SUM,  B_COEF,  JMP_NONE,     ST_DONE};
    endcase
  end

endmodule

// ----- rtl/ascu_mul.sv -----
// shared chunked multiplier with product accumulator
// depends on ascu_pkg for operand widths and mul_op_t
module ascu_mul import ascu_pkg::*; (
  input  logic               clk,
  input  mul_op_t            op,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [ACC_W-1:0]   acc
);

  logic [MUL_CHUNK_W-1:0] chunk;
  logic [PROD_W-1:0]      prod;

  assign chunk = (op == MUL_HI) ? a[MUL_A_W-1:MUL_CHUNK_W] : a[MUL_CHUNK_W-1:0];
  assign prod  = PROD_W'(chunk) * PROD_W'(b);

  always_ff @(posedge clk) begin
    unique case (op)
      MUL_LO:  acc <= ACC_W'(prod);
      MUL_HI:  acc <= acc + {prod, {MUL_CHUNK_W{1'b0}}};
      default: ;
    endcase
  end

endmodule

// ----- rtl/ascu_core.sv -----
// step counter, filter state and datapath driven by the microcode word
// depends on ascu_pkg, the channel interfaces in ascu_if and ascu_mul
module ascu_core import ascu_pkg::*; #(
  parameter int AVERAGE_MEASURES = AVG_MEASURES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  uword_t            uw,
  output logic [STEP_W-1:0] step,
  ascu_in_if.sink           frame,
  ascu_out_if.source        result
);

  logic busy;
  logic res_valid;
  logic out_free;
  logic take;

  logic [N_W-1:0]          n;
  logic signed [CLK_W-1:0] aclk;
  logic signed [CLK_W-1:0] mclk;
  logic                    cvalid;
  logic [DIFF_W-1:0]       diff;
  logic [DIFF_W-1:0]       dmag;
  logic                    dneg;
  logic [SUM_W-1:0]        sum;
  logic [SUM_W-1:0]        smag;
  logic                    sneg;
  logic [CNT_W-1:0]        cnt;
  logic [WANT_W-1:0]       lo;
  logic [WANT_W-1:0]       hi;
  logic [WANT_W-1:0]       wanted;
  logic [WANT_W-1:0]       res_data;

  mul_op_t            mop;
  logic [MUL_A_W-1:0] ma;
  logic [MUL_B_W-1:0] mb;
  logic [ACC_W-1:0]   acc;
  logic [ACCQ_W-1:0]  acc_q;

  logic [SUM_W-1:0]        sum_mag;
  logic signed [59:0]      s_wide;
  logic [SUM_W-1:0]        sum_sat;
  logic [DIV_IN_W-1:0]     n9;
  logic [DIV_IN_W-1:0]     n11;
  logic signed [60:0]      w_wide;
  logic signed [60:0]      lo_wide;
  logic signed [60:0]      hi_wide;
  logic [WANT_W-1:0]       clip_val;

  assign frame.ready           = !busy && !rst;
  assign result.valid          = res_valid;
  assign result.wanted_samples = res_data;
  assign out_free              = !res_valid || result.ready;

  // shared multiplier operands
  assign mop   = busy ? uw.mul : MUL_NONE;
  assign ma    = (uw.a_sel == A_DIFF) ? MUL_A_W'(dmag) : smag;
  assign acc_q = acc[ACC_W-1:FRAC_W];

  always_comb begin
    unique case (uw.b_sel)
      B_COEF:  mb = MUL_B_W'(cfg.coef);
      B_COMPL: mb = MUL_B_W'(17'h10000 - {1'b0, cfg.coef});
      B_RATE:  mb = cfg.rate;
      default: mb = '0;
    endcase
  end

  ascu_mul u_mul (
    .clk (clk),
    .op  (mop),
    .a   (ma),
    .b   (mb),
    .acc (acc)
  );

  // jump conditions
  always_comb begin
    unique case (uw.jmp)
      JMP_MASTER:   take = cfg.master;
      JMP_NOSYNC:   take = !cvalid || (dmag >= DIFF_W'(cfg.nosync_thr));
      JMP_COUNTING: take = cnt < CNT_W'(AVERAGE_MEASURES);
      JMP_BELOW:    take = acc_q < ACCQ_W'(cfg.corr_thr);
      default:      take = 1'b0;
    endcase
  end

  // filter update with saturation to the sum range
  assign sum_mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
  assign s_wide  = 60'(signed'(diff)) +
                   (sneg ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q}));

  always_comb begin
    if (s_wide[59:SUM_W-1] == '0 || s_wide[59:SUM_W-1] == '1) begin
      sum_sat = s_wide[SUM_W-1:0];
    end else if (s_wide[59]) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  // clip bounds n*9/10 and n*11/10
  assign n9  = DIV_IN_W'(n) + DIV_IN_W'({n, 3'b000});
  assign n11 = DIV_IN_W'(n) + DIV_IN_W'({n, 1'b0}) + DIV_IN_W'({n, 3'b000});

  assign w_wide  = $signed(61'(n)) +
                   (dneg ? -$signed({2'b00, acc_q}) : $signed({2'b00, acc_q}));
  assign lo_wide = $signed(61'(lo));
  assign hi_wide = $signed(61'(hi));

  always_comb begin
    if (w_wide < lo_wide) begin
      clip_val = lo;
    end else if (w_wide > hi_wide) begin
      clip_val = hi;
    end else begin
      clip_val = w_wide[WANT_W-1:0];
    end
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= ST_DIFF;
      res_valid <= 1'b0;
      sum       <= '0;
      cnt       <= '0;
    end else begin
      // output register: load a finished request, else drain on ready
      if (busy && uw.act == ACT_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (!busy) begin
        if (frame.valid) begin
          busy <= 1'b1;
          step <= ST_DIFF;
        end
      end else begin
        if (uw.act == ACT_DONE) begin
          if (out_free) begin
            busy <= 1'b0;
          end
        end else if (take) begin
          step <= uw.target;
        end else begin
          step <= step + 1'b1;
        end
        if (uw.act == ACT_CHECK && take) begin
          sum <= '0;
          cnt <= '0;
        end
        if (uw.act == ACT_UPDATE) begin
          sum <= sum_sat;
          if (take) begin
            cnt <= cnt + 1'b1;
          end
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (frame.valid && !busy) begin
      n      <= frame.frame_samples;
      aclk   <= frame.audio_clock;
      mclk   <= frame.master_clock;
      cvalid <= frame.clocks_valid;
    end
    if (busy) begin
      unique case (uw.act)
        ACT_DIFF: begin
          diff <= DIFF_W'(aclk) - DIFF_W'(mclk);
          smag <= sum_mag;
          sneg <= sum[SUM_W-1];
        end
        ACT_ABS: begin
          dmag <= diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
          dneg <= diff[DIFF_W-1];
        end
        ACT_MAG: begin
          smag <= sum_mag;
          sneg <= sum[SUM_W-1];
        end
        ACT_THRESH: begin
          lo <= div10(n9);
          hi <= div10(n11);
        end
        ACT_CLIP: wanted <= clip_val;
        ACT_DONE: begin
          if (out_free) begin
            res_data <= wanted;
          end
        end
        default: ;
      endcase
      if (take) begin
        wanted <= WANT_W'(n);
      end
    end
  end

endmodule

// ----- rtl/audio_sync_sample_correction_unit.sv -----
// top level of the audio sync sample correction unit
// depends on ascu_pkg, ascu_if, ascu_cfg, ascu_rom, ascu_core (and ascu_mul inside it)
//
//   channel   dir   protocol         carries
//   -------   ---   --------------   ---------------------------------------------
//   frame     in    valid / ready    frame_samples, audio_clock, master_clock,
//                                    clocks_valid
//   result    out   valid / ready    wanted_samples
//   apb       in    psel / penable   five config registers at byte address 4*index
//
// one request at a time; frame.ready is high whenever the sequencer is idle and
//   out of reset
// the length of a request, counted from acceptance to the next possible acceptance,
//   depends on its path: audio is master, the filter is cleared, the filter is
//   still gathering measures, the averaged error is below threshold, or a full
//   correction; the step count of the microcode program through the one shared
//   28x19 multiplier (two passes per product) sets it
// the result sits in an output register; a stalled result only holds the
//   sequencer in its final step, a new request is still taken once it moves on
// rst is synchronous and active high; it clears the filter sum, the measure count,
//   the sequencer and restores the register defaults
module audio_sync_sample_correction_unit import ascu_pkg::*; #(
  parameter int AVERAGE_MEASURES = AVG_MEASURES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  ascu_in_if.sink           frame,
  ascu_out_if.source        result
);

  cfg_t              cfg;     // live register values
  uword_t            uw;      // control word of the current step
  logic [STEP_W-1:0] step;    // microcode step counter

  // register file behind the apb port
  ascu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // program store: diff, abs, nosync check, filter product, update, magnitude,
  // average product, threshold, rate product, clip, deliver
  ascu_rom u_rom (
    .step (step),
    .uw   (uw)
  );

  // sequencer and datapath
  ascu_core #(
    .AVERAGE_MEASURES (AVERAGE_MEASURES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .uw     (uw),
    .step   (step),
    .frame  (frame),
    .result (result)
  );

endmodule

// ----- test/tb_audio_sync_sample_correction_unit.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the audio sync sample correction unit
// depends on ascu_pkg, ascu_if and the rtl top level audio_sync_sample_correction_unit
module tb_audio_sync_sample_correction_unit;
  import ascu_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int LIMIT_CYCLES  = 600000;
  // margin for the sequencer to go idle, well past its longest request
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;

  localparam logic [2:0] REG_UNMAPPED = 3'd5;

  localparam logic signed [CLK_W-1:0] CLK_MAX = {1'b0, {(CLK_W-1){1'b1}}};
  localparam logic signed [CLK_W-1:0] CLK_MIN = {1'b1, {(CLK_W-1){1'b0}}};

  // saturation limits of the 56-bit filter sum
  localparam longint SUM_HI = longint'((64'd1 << (SUM_W-1)) - 64'd1);
  localparam longint SUM_LO = -SUM_HI - 64'sd1;

  typedef struct {
    logic [N_W-1:0]          samples;
    logic signed [CLK_W-1:0] audio;
    logic signed [CLK_W-1:0] master;
    logic                    ok;
  } frame_req_t;

  typedef enum {ROW_FRAME, ROW_WRITE} row_kind_t;

  // one line of the directed table: either a register write or a frame request,
  // the latter with an optional hand-typed wanted count
  typedef struct {
    row_kind_t         kind;
    logic [2:0]        idx;
    logic [DATA_W-1:0] value;
    frame_req_t        req;
    bit                typed;
    logic [WANT_W-1:0] want;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ascu_in_if  frame_ch();
  ascu_out_if result_ch();

  audio_sync_sample_correction_unit #(
    .AVERAGE_MEASURES(AVG_MEASURES_DEF)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .frame   (frame_ch.sink),
    .result  (result_ch.source)
  );

  // shadow of the register file and of the drift filter
  cfg_t        cfg_shadow;
  longint      drift_sum;
  int unsigned measures_seen;

  // wanted counts still owed by the block, oldest first
  logic [WANT_W-1:0] wanted_backlog[$];
  stim_row_t         directed_rows[$];

  int unsigned errors;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  logic [WANT_W-1:0] want_head;

  always begin
    clk = 1'b0;
    #(CLK_PERIOD/2);
    clk = 1'b1;
    #(CLK_PERIOD/2);
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // trunc(m * f / 2^16), exact through a wide product
  function automatic logic [63:0] scale_q16(input logic [63:0] m, input logic [63:0] f);
    logic [127:0] p;
    p = 128'(m) * 128'(f);
    return p[79:16];
  endfunction

  task automatic reset_shadow();
    cfg_shadow.master     = 1'b0;
    cfg_shadow.coef       = COEF_RST;
    cfg_shadow.corr_thr   = CORR_RST;
    cfg_shadow.nosync_thr = NOSYNC_RST;
    cfg_shadow.rate       = RATE_RST;
    drift_sum             = 0;
    measures_seen         = 0;
  endtask

  // advances the filter shadow by one frame and returns the count the block must give
  function automatic logic [WANT_W-1:0] predict_wanted(input frame_req_t r);
    longint      n, want, diff, sum, lo, hi;
    logic [63:0] dmag, pm, am, sm;
    n    = longint'(r.samples);
    want = n;
    if (!cfg_shadow.master) begin
      diff = longint'(r.audio) - longint'(r.master);
      dmag = magnitude(diff);
      if (r.ok && dmag < 64'(cfg_shadow.nosync_thr)) begin
        // decay uses the sign of the old sum
        pm  = scale_q16(magnitude(drift_sum), 64'(cfg_shadow.coef));
        sum = diff + ((drift_sum < 0) ? -longint'(pm) : longint'(pm));
        if (sum > SUM_HI) sum = SUM_HI;
        if (sum < SUM_LO) sum = SUM_LO;
        drift_sum = sum;
        if (measures_seen < AVG_MEASURES_DEF) begin
          measures_seen++;
        end else begin
          am = scale_q16(magnitude(drift_sum), 64'd65536 - 64'(cfg_shadow.coef));
          if (am >= 64'(cfg_shadow.corr_thr)) begin
            sm   = (dmag * 64'(cfg_shadow.rate)) >> FRAC_W;
            lo   = n * 90 / 100;
            hi   = n * 110 / 100;
            want = (diff < 0) ? n - longint'(sm) : n + longint'(sm);
            if (want < lo) want = lo;
            if (want > hi) want = hi;
          end
        end
      end else begin
        drift_sum     = 0;
        measures_seen = 0;
      end
    end
    return want[WANT_W-1:0];
  endfunction

  task automatic apply_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    case (idx)
      REG_MASTER:     cfg_shadow.master     = value[0];
      REG_COEF:       cfg_shadow.coef       = value[COEF_W-1:0];
      REG_CORR_THR:   cfg_shadow.corr_thr   = value[THR_W-1:0];
      REG_NOSYNC_THR: cfg_shadow.nosync_thr = value[THR_W-1:0];
      REG_RATE:       cfg_shadow.rate       = value[RATE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] shadow_value(input logic [2:0] idx);
    case (idx)
      REG_MASTER:     return DATA_W'(cfg_shadow.master);
      REG_COEF:       return DATA_W'(cfg_shadow.coef);
      REG_CORR_THR:   return DATA_W'(cfg_shadow.corr_thr);
      REG_NOSYNC_THR: return DATA_W'(cfg_shadow.nosync_thr);
      REG_RATE:       return DATA_W'(cfg_shadow.rate);
      default:        return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------

  // setup phase, access phase, then psel drops before the task returns so back-to-back calls never
  // drive psel twice in one step; read data is taken at the completing edge
  task automatic apb_xfer(input logic [2:0] idx, input bit wr,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write, update the shadow, and read back mapped registers
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd;
    apb_xfer(idx, 1'b1, value, rd);
    apply_write(idx, value);
    if (idx <= REG_RATE) begin
      apb_xfer(idx, 1'b0, '0, rd);
      if (rd !== shadow_value(idx)) begin
        $display("%0t: register %0d readback expected %0h got %0h",
                 $time, idx, shadow_value(idx), rd);
        errors++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // frame requests
  // ---------------------------------------------------------------------------

  // holds the request until the block takes it, then books the wanted count
  task automatic offer_frame(input frame_req_t r, input bit typed,
                             input logic [WANT_W-1:0] want);
    logic [WANT_W-1:0] predicted;
    frame_ch.valid         <= 1'b1;
    frame_ch.frame_samples <= r.samples;
    frame_ch.audio_clock   <= r.audio;
    frame_ch.master_clock  <= r.master;
    frame_ch.clocks_valid  <= r.ok;
    do @(posedge clk); while (frame_ch.ready !== 1'b1);
    predicted = predict_wanted(r);
    wanted_backlog.push_back(typed ? want : predicted);
  endtask

  // random idle burst on the request side
  task automatic sender_gap();
    if ($urandom_range(0, 99) < send_gap_pct) begin
      frame_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // drop valid, wait until every booked count came back, then let the sequencer go idle
  task automatic settle();
    frame_ch.valid <= 1'b0;
    while (wanted_backlog.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [DATA_W-1:0] master, input logic [DATA_W-1:0] coef,
                           input logic [DATA_W-1:0] corr, input logic [DATA_W-1:0] nosync,
                           input logic [DATA_W-1:0] rate);
    settle();
    write_reg(REG_MASTER, master);
    write_reg(REG_COEF, coef);
    write_reg(REG_CORR_THR, corr);
    write_reg(REG_NOSYNC_THR, nosync);
    write_reg(REG_RATE, rate);
  endtask

  // ---------------------------------------------------------------------------
  // random content
  // ---------------------------------------------------------------------------

  function automatic logic [N_W-1:0] pick_samples();
    case ($urandom_range(0, 5))
      0:       return N_W'(1024);
      1:       return N_W'(960);
      2, 3:    return N_W'($urandom_range(0, 4095));
      4:       return N_W'($urandom_range(0, 65535));
      default: return $urandom_range(0, 1) ? {N_W{1'b1}} : {N_W{1'b0}};
    endcase
  endfunction

  // clock offset for a session from one of four size classes, the last drawn below the current no-sync limit
  function automatic longint pick_drift();
    longint mag;
    case ($urandom_range(0, 3))
      0:       mag = $urandom_range(0, 64);
      1:       mag = $urandom_range(0, 4095);
      2:       mag = $urandom_range(0, 262143);
      default: mag = (cfg_shadow.nosync_thr == 0) ? 0 :
                     longint'({$urandom}) % longint'(cfg_shadow.nosync_thr);
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic frame_req_t noise_frame();
    frame_req_t r;
    longint     mag;
    r.samples = N_W'($urandom_range(0, 65535));
    r.audio   = CLK_W'({$urandom, $urandom});
    r.master  = CLK_W'({$urandom, $urandom});
    r.ok      = 1'b1;
    case ($urandom_range(0, 3))
      0: r.ok = 1'($urandom_range(0, 1));
      1: r.ok = 1'b0;
      2: begin
        // offset at or past the no-sync limit
        r.master = r.master >>> 1;
        mag      = longint'(cfg_shadow.nosync_thr) + longint'($urandom_range(0, 1000));
        r.audio  = r.master + CLK_W'($urandom_range(0, 1) ? -mag : mag);
      end
      default: begin
        r.samples = $urandom_range(0, 1) ? {N_W{1'b1}} : {N_W{1'b0}};
        r.audio   = $urandom_range(0, 1) ? CLK_MAX : CLK_MIN;
        r.master  = $urandom_range(0, 1) ? CLK_MAX : CLK_MIN;
      end
    endcase
    return r;
  endfunction

  // mostly sessions of steady drift long enough to fill the averager,
  // the rest single noise requests
  task automatic run_traffic(input int unsigned count);
    int unsigned             left, len, k;
    longint                  drift, jit;
    logic signed [CLK_W-1:0] base;
    logic [N_W-1:0]          n_base;
    frame_req_t              r;
    left = count;
    while (left != 0) begin
      if ($urandom_range(0, 99) < 80) begin
        len    = $urandom_range(20, 60);
        drift  = pick_drift();
        base   = CLK_W'({$urandom, $urandom});
        base   = base >>> 1;
        n_base = pick_samples();
        for (k = 0; k < len && left != 0; k++) begin
          jit       = longint'($urandom_range(0, 64)) - 32;
          r.samples = ($urandom_range(0, 7) == 0) ? pick_samples() : n_base;
          r.master  = base;
          r.audio   = base + CLK_W'(drift + jit);
          // an occasional lost clock breaks the session
          r.ok      = ($urandom_range(0, 49) != 0);
          offer_frame(r, 1'b0, '0);
          left--;
          sender_gap();
          base = base + CLK_W'($urandom_range(0, 65536));
          if ($urandom_range(0, 9) == 0) drift = drift + jit * 16;
        end
      end else begin
        r = noise_frame();
        offer_frame(r, 1'b0, '0);
        left--;
        sender_gap();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------

  task automatic plan_frame(input logic [N_W-1:0] n, input logic signed [CLK_W-1:0] audio,
                            input logic signed [CLK_W-1:0] master, input logic ok,
                            input bit typed, input logic [WANT_W-1:0] want);
    stim_row_t row;
    row.kind        = ROW_FRAME;
    row.idx         = '0;
    row.value       = '0;
    row.req.samples = n;
    row.req.audio   = audio;
    row.req.master  = master;
    row.req.ok      = ok;
    row.typed       = typed;
    row.want        = want;
    directed_rows.push_back(row);
  endtask

  task automatic plan_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    stim_row_t row;
    row.kind        = ROW_WRITE;
    row.idx         = idx;
    row.value       = value;
    row.req.samples = '0;
    row.req.audio   = '0;
    row.req.master  = '0;
    row.req.ok      = 1'b0;
    row.typed       = 1'b0;
    row.want        = '0;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed();
    // clocks undefined: count passes through, smallest and largest frame
    plan_frame(16'd0, '0, '0, 1'b0, 1'b1, 17'd0);
    plan_frame(16'd65535, CLK_MAX, CLK_MIN, 1'b0, 1'b1, 17'd65535);
    // offsets far beyond the no-sync limit, both signs
    plan_frame(16'd1000, CLK_MAX, CLK_MIN, 1'b1, 1'b1, 17'd1000);
    plan_frame(16'd1000, CLK_MIN, CLK_MAX, 1'b1, 1'b1, 17'd1000);
    // offset exactly at the no-sync limit clears, one below it is measured
    plan_frame(16'd4096, 48'sd655360, 48'sd0, 1'b1, 1'b1, 17'd4096);
    plan_frame(16'd4096, 48'sd0, 48'sd655359, 1'b1, 1'b1, 17'd4096);
    // still counting measures
    plan_frame(16'd4096, -48'sd5, -48'sd5, 1'b1, 1'b1, 17'd4096);
    // wide write to the master flag keeps only bit 0, here still clear
    plan_write(REG_MASTER, 32'hFFFF_FFFE);
    plan_frame(16'd2000, 48'sh0100_0000_0000, 48'sd0, 1'b1, 1'b1, 17'd2000);
    // audio is master: pass through, filter untouched
    plan_write(REG_MASTER, 32'h0000_0003);
    plan_frame(16'd300, 48'sd17, -48'sd9, 1'b0, 1'b1, 17'd300);
    plan_frame(16'd65535, CLK_MAX, CLK_MIN, 1'b1, 1'b1, 17'd65535);
    plan_frame(16'd1024, 48'sd700, 48'sd0, 1'b1, 1'b0, '0);
    plan_write(REG_MASTER, 32'h0);
    // zero no-sync limit clears on every frame
    plan_write(REG_NOSYNC_THR, 32'h0);
    plan_frame(16'd512, 48'sd0, 48'sd0, 1'b1, 1'b1, 17'd512);
    plan_write(REG_NOSYNC_THR, 32'hFFFF_FFFF);
    // masked writes leave a zero rate and a zero weight
    plan_write(REG_RATE, 32'hFFF8_0000);
    plan_write(REG_COEF, 32'hFFFF_0000);
    plan_write(REG_CORR_THR, 32'h0);
    // write to a hole in the map is dropped
    plan_write(REG_UNMAPPED, 32'h1234_5678);
    plan_frame(16'd1500, 48'sd65536, 48'sd0, 1'b1, 1'b0, '0);
    plan_frame(16'd1500, -48'sd65536, 48'sd0, 1'b1, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // random stalls, plus one long hold-off on request so the output register
  // fills and the block stops taking frames
  initial begin : result_drain
    result_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // compare every accepted result with the oldest booked count
  always @(posedge clk) begin
    if (rst === 1'b0 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (wanted_backlog.size() == 0) begin
        $display("%0t: wanted_samples expected none got %0d", $time,
                 result_ch.wanted_samples);
        errors++;
      end else begin
        want_head = wanted_backlog.pop_front();
        if (result_ch.wanted_samples !== want_head) begin
          $display("%0t: wanted_samples expected %0d got %0d", $time, want_head,
                   result_ch.wanted_samples);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned i;
    stim_row_t   row;
    errors         = 0;
    hold_req       = 1'b0;
    send_gap_pct   = 20;
    recv_stall_pct = 20;
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    frame_ch.valid         <= 1'b0;
    frame_ch.frame_samples <= '0;
    frame_ch.audio_clock   <= '0;
    frame_ch.master_clock  <= '0;
    frame_ch.clocks_valid  <= 1'b0;
    reset_shadow();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, register rows only once the block is idle
    build_directed();
    for (i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.idx, row.value);
      end else begin
        offer_frame(row.req, row.typed, row.want);
        sender_gap();
      end
    end

    // reset defaults, no idling at all
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    configure(32'h0, 32'd52016, 32'd1311, 32'd655360, 32'd48000);
    run_traffic(300);

    // lowest weight and threshold, slowest rate: every filled filter corrects
    send_gap_pct   = 30;
    recv_stall_pct = 30;
    configure(32'h0, 32'h0, 32'h0, 32'd655360, 32'd1);
    run_traffic(200);

    // heaviest weight, threshold never reached, widest no-sync window, top rate
    send_gap_pct   = 20;
    recv_stall_pct = 20;
    configure(32'h0, 32'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd384000);
    run_traffic(200);

    // heaviest weight with a low threshold and the largest rate the field holds;
    // the receiver holds off for a long stretch while frames keep coming
    send_gap_pct   = 5;
    recv_stall_pct = 10;
    configure(32'h0, 32'd65535, 32'd100, 32'hFFFF_FFFF, 32'h0007_FFFF);
    hold_req = 1'b1;
    run_traffic(200);

    // two random settings
    configure(32'h0, $urandom_range(0, 65535), $urandom_range(0, 8000), $urandom,
              $urandom_range(1, 384000));
    run_traffic(200);
    send_gap_pct   = 40;
    recv_stall_pct = 10;
    configure(32'h0, $urandom_range(0, 65535), $urandom_range(0, 8000), $urandom,
              $urandom_range(1, 384000));
    run_traffic(200);

    // rate of zero through a masked write: correction adds nothing
    send_gap_pct   = 10;
    recv_stall_pct = 40;
    configure(32'h0, 32'd52016, 32'd0, 32'd655360, 32'h0008_0000);
    run_traffic(100);

    // audio is master
    configure(32'h1, $urandom_range(0, 65535), $urandom, $urandom, $urandom_range(1, 384000));
    run_traffic(100);

    // zero no-sync limit
    configure(32'h0, 32'd52016, 32'd1311, 32'h0, 32'd48000);
    run_traffic(60);

    // a typical 44.1 kHz setup under heavy idling on both sides
    send_gap_pct   = 50;
    recv_stall_pct = 50;
    configure(32'h0, 32'd40000, 32'd500, 32'd2000000, 32'd44100);
    run_traffic(100);

    // closing stretch at full rate
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    configure(32'h0, 32'd52016, 32'd1311, 32'd655360, 32'd48000);
    run_traffic(280);

    settle();
    if (errors == 0) begin
      $display("tb_audio_sync_sample_correction_unit: PASS");
    end else begin
      $display("tb_audio_sync_sample_correction_unit: FAIL");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb_audio_sync_sample_correction_unit: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ascu_pkg.sv
rtl/ascu_if.sv
rtl/ascu_cfg.sv
rtl/ascu_rom.sv
rtl/ascu_mul.sv
rtl/ascu_core.sv
rtl/audio_sync_sample_correction_unit.sv
test/tb_audio_sync_sample_correction_unit.sv
